// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    // default number of entries
    localparam int unsigned QUEUE_DEPTH = 16;

    // request and result field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRI_W   = 16;
    localparam int unsigned OCC_W   = 5;

    // packed stream widths
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 40;

    // request kinds
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// ===== design/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Sorted priority queue, highest priority at the head.
// Slave channel s_axis carries requests: tuser selects insert (0) or remove (1),
// tdata holds the value and priority of an insert. Master channel m_axis returns
// exactly one result per request: the removed value (zero unless a remove
// succeeded), the new occupancy and a status of done, empty or full.
// An insert goes behind every entry of strictly higher priority and ahead of
// entries of equal or lower priority; an insert into a full queue and a remove
// from an empty one leave the queue unchanged.
// Request and result are registered: the request register, then the entry
// update and result register. Throughput: one request per cycle while the
// receiver takes results; the whole entry file compares and shifts in parallel.
// Reset (synchronous, active low) empties the queue and drops both pipeline
// registers; entry contents are not cleared since only held entries are read.
// When the receiver stalls, the finished result holds in the output register,
// one more request is held in the input register, then tready falls until the
// result is taken.
module sorted_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [31:0] item_value, [47:32] item_priority
    input  logic [spq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] op
    input  logic [0:0]                     i_s_axis_tuser,
    // result channel
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] removed_value, [36:32] occupancy, [39:37] zero
    output logic [spq_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]                     o_m_axis_tuser
);

    localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned VALUE_W = spq_pkg::VALUE_W;
    localparam int unsigned PRI_W   = spq_pkg::PRI_W;
    localparam int unsigned OCC_W   = spq_pkg::OCC_W;

    // request register
    logic                      r_in_valid;
    spq_pkg::t_op              r_in_op;
    logic [VALUE_W-1:0]        r_in_value;
    logic signed [PRI_W-1:0]   r_in_pri;

    // entry file and fill count
    logic [VALUE_W-1:0]        r_val [QUEUE_DEPTH];
    logic signed [PRI_W-1:0]   r_pri [QUEUE_DEPTH];
    logic [VALUE_W-1:0]        n_val [QUEUE_DEPTH];
    logic signed [PRI_W-1:0]   n_pri [QUEUE_DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;

    // result register
    logic                      r_out_valid;
    logic [VALUE_W-1:0]        r_out_value;
    spq_pkg::t_status          r_out_status;
    logic [CNT_W-1:0]          r_out_count;

    logic [VALUE_W-1:0]        n_out_value;
    spq_pkg::t_status          n_out_status;

    logic                      proc_fire;
    logic                      s_fire;
    logic                      is_full;
    logic                      is_empty;
    logic                      do_insert;
    logic                      do_remove;
    logic [QUEUE_DEPTH-1:0]    higher;

    // handshake
    assign proc_fire       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc_fire;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    assign is_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty  = (r_count == '0);
    assign do_insert = proc_fire && (r_in_op == spq_pkg::OP_INSERT) && !is_full;
    assign do_remove = proc_fire && (r_in_op == spq_pkg::OP_REMOVE) && !is_empty;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_op    <= spq_pkg::t_op'(i_s_axis_tuser[0]);
            r_in_value <= i_s_axis_tdata[VALUE_W-1:0];
            r_in_pri   <= i_s_axis_tdata[VALUE_W +: PRI_W];
        end
    end

    // held entries that outrank the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            higher[i] = (CNT_W'(i) < r_count) && (r_pri[i] > r_in_pri);
        end
    end

    // next entry file: parallel insert shift or remove shift
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
        end
        if (do_insert) begin
            if (!higher[0]) begin
                n_val[0] = r_in_value;
                n_pri[0] = r_in_pri;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (!higher[i]) begin
                    if (higher[i-1]) begin
                        n_val[i] = r_in_value;
                        n_pri[i] = r_in_pri;
                    end else begin
                        n_val[i] = r_val[i-1];
                        n_pri[i] = r_pri[i-1];
                    end
                end
            end
        end else if (do_remove) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_val[i] = r_val[i+1];
                n_pri[i] = r_pri[i+1];
            end
        end
    end

    // next fill count and result
    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = spq_pkg::ST_DONE;
        case (r_in_op)
            spq_pkg::OP_INSERT: begin
                if (is_full) begin
                    n_out_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spq_pkg::OP_REMOVE: begin
                if (is_empty) begin
                    n_out_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_count     = r_count - CNT_W'(1);
                    n_out_value = r_val[0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // entry file
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_val[i] <= n_val[i];
            r_pri[i] <= n_pri[i];
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (proc_fire) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_count  <= n_count;
        end
    end

    // result channel
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(spq_pkg::M_TDATA_W - VALUE_W - OCC_W){1'b0}},
                              OCC_W'(r_out_count), r_out_value};
    assign o_m_axis_tuser  = r_out_status;

    // checks
`include "assert_macros.svh"

    `SPQ_ASSERT(a_count_bound, r_count <= CNT_W'(QUEUE_DEPTH), "fill count beyond depth")
    `SPQ_ASSERT(a_head_sorted, r_count >= CNT_W'(2) |-> r_pri[0] >= r_pri[1], "head out of order")
    `SPQ_ASSERT(a_full_refused, do_insert |-> !is_full, "insert accepted while full")
    `SPQ_ASSERT(a_count_step, proc_fire && r_in_op == spq_pkg::OP_REMOVE && !is_empty |=> r_count == $past(r_count) - CNT_W'(1), "remove did not drop count")
    `SPQ_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> r_count == '0 && !r_out_valid && !r_in_valid, "reset left state")

endmodule

// ===== tb/sv/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel as seen at the block
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    // [31:0] item_value, [47:32] item_priority
    input  logic [S_TDATA_W-1:0]  i_req_data,
    // [0] op
    input  logic [0:0]            i_req_op,
    // result channel as seen at the block
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // [31:0] removed_value, [36:32] occupancy, [39:37] zero
    input  logic [M_TDATA_W-1:0]  i_res_data,
    // [1:0] status
    input  logic [1:0]            i_res_status,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRI_W-1:0]   pri;
    } t_entry;

    typedef struct {
        logic [VALUE_W-1:0] removed;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

    // entries held by the queue, head first
    t_entry  held_entries[$];
    // results still owed by the block, oldest first
    t_result owed_results[$];
    int      error_total = 0;

    // apply one request to the held entries and return the result it causes
    function automatic t_result apply_request(t_op op, logic signed [VALUE_W-1:0] value,
                                              logic signed [PRI_W-1:0] pri);
        t_result r;
        t_entry  e;
        int      pos;
        r.removed = '0;
        r.status  = ST_DONE;
        if (op == OP_INSERT) begin
            if (held_entries.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // newest goes ahead of equal priorities, the head included
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].pri > pri)
                    pos++;
                e.value = value;
                e.pri   = pri;
                held_entries.insert(pos, e);
            end
        end else if (held_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e = held_entries.pop_front();
            r.removed = e.value;
        end
        r.occupancy = OCC_W'(held_entries.size());
        return r;
    endfunction

    task automatic note_error(string msg);
        if (error_total < 10)
            $display("%0.1f ns: mismatch: %s", $realtime, msg);
        error_total++;
    endtask

    // compare results first, then predict for the request taken on the same edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held_entries.delete();
            owed_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (owed_results.size() == 0) begin
                    note_error($sformatf("result with none owed: data %h status %0d",
                                         i_res_data, i_res_status));
                end else begin
                    want = owed_results.pop_front();
                    if (i_res_data[VALUE_W-1:0] !== want.removed)
                        note_error($sformatf("removed_value expected %h got %h",
                                             want.removed, i_res_data[VALUE_W-1:0]));
                    if (i_res_data[VALUE_W +: OCC_W] !== want.occupancy)
                        note_error($sformatf("occupancy expected %0d got %0d",
                                             want.occupancy, i_res_data[VALUE_W +: OCC_W]));
                    if (i_res_status !== want.status)
                        note_error($sformatf("status expected %0d got %0d",
                                             want.status, i_res_status));
                    if (i_res_data[M_TDATA_W-1:VALUE_W+OCC_W] !== '0)
                        note_error($sformatf("padding bits expected 0 got %b",
                                             i_res_data[M_TDATA_W-1:VALUE_W+OCC_W]));
                end
            end
            if (i_req_valid && i_req_ready)
                owed_results.push_back(apply_request(t_op'(i_req_op[0]),
                                                     i_req_data[VALUE_W-1:0],
                                                     i_req_data[VALUE_W +: PRI_W]));
        end
        o_fail_count <= error_total;
        o_pending    <= owed_results.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [31:0] item_value, [47:32] item_priority
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // [0] op
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] removed_value, [36:32] occupancy, [39:37] zero
    logic [M_TDATA_W-1:0] m_tdata;
    // [1:0] status
    logic [1:0]           m_tuser;

    int fail_count;
    int pending_count;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int long_holds_asked = 0;

    sorted_priority_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    spq_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_req_op     (s_tuser),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .i_res_status (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when one is asked for
    initial begin
        int stall_left = 0;
        int holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (holds_done < long_holds_asked) begin
                holds_done++;
                m_tready   <= 1'b0;
                stall_left = 150;
            end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
                m_tready   <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one request and hold it until taken
    task automatic send_request(t_op op, logic signed [VALUE_W-1:0] value,
                                logic signed [PRI_W-1:0] pri);
        s_tvalid <= 1'b1;
        s_tdata  <= {pri, value};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // optional gap after a request, mostly short
    task automatic sender_pause();
        int r;
        int gap;
        gap = 0;
        if (tx_idle_en) begin
            r = $urandom_range(0, 99);
            if (r >= 97)
                gap = $urandom_range(10, 30);
            else if (r >= 75)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(t_op op, logic signed [VALUE_W-1:0] value,
                         logic signed [PRI_W-1:0] pri);
        send_request(op, value, pri);
        sender_pause();
    endtask

    // priorities mix full range, extremes and narrow sets that force ties
    function automatic logic signed [PRI_W-1:0] pick_priority();
        logic signed [PRI_W-1:0] p;
        case ($urandom_range(0, 3))
            0: p = PRI_W'($urandom);
            1: p = PRI_W'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: p = 16'sh8000;
                    1: p = 16'sh7fff;
                    2: p = 16'shffff;
                    default: p = 16'sh0000;
                endcase
            end
            default: p = PRI_W'($urandom_range(0, 8)) - 16'sd4;
        endcase
        return p;
    endfunction

    task automatic random_request(int insert_pct);
        t_op op;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        issue(op, VALUE_W'($urandom), pick_priority());
    endtask

    initial begin
        int insert_pct;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty remove, extremes, ties at head, middle and tail, full
        issue(OP_REMOVE, 32'sh12345678, 16'sh0055);
        issue(OP_INSERT, 32'sh7fffffff, 16'sh7fff);
        issue(OP_INSERT, 32'sh80000000, 16'sh8000);
        issue(OP_INSERT, 32'sh00000000, 16'sh0000);
        issue(OP_INSERT, 32'shffffffff, 16'shffff);
        issue(OP_INSERT, 32'sh00000001, 16'sh7fff);
        issue(OP_INSERT, 32'sh00000002, 16'sh0000);
        issue(OP_INSERT, 32'sh00000003, 16'sh8000);
        for (int i = 0; i < 9; i++)
            issue(OP_INSERT, 32'sh00000100 + i, PRI_W'(i * 100 - 400));
        issue(OP_INSERT, 32'sh00000005, 16'sh0000);
        repeat (7) issue(OP_REMOVE, 32'shdeadbeef, 16'sh7fff);

        // random phases with varying insert bias and idling
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 3)
                0: insert_pct = 70;
                1: insert_pct = 50;
                default: insert_pct = 30;
            endcase
            tx_idle_en = (phase != 0 && phase != 6 && phase != 4);
            rx_idle_en = (phase != 0 && phase != 6);
            // long receiver hold-off while requests keep coming
            if (phase == 4)
                long_holds_asked++;
            repeat (152) random_request(insert_pct);
        end
        s_tvalid <= 1'b0;

        // drain, once the last request shows up in the owed count
        rx_idle_en = 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/spq_pkg.sv
design/sorted_priority_queue.sv
tb/sv/spq_checker.sv
tb/sv/testbench.sv
